@@ src/idee_pkg.sv @@
// ----------------------------------------------------------------------------
// idee_pkg: shared types and constants of the infix digit evaluator
// Character codes, item classes, status codes and the queue item layout.
// ----------------------------------------------------------------------------
package idee_pkg;

   localparam int unsigned OUT_W       = 32;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;

   typedef enum logic [2:0] {
      K_DIGIT,
      K_ADD,
      K_SUB,
      K_MUL,
      K_DIV,
      K_OTHER
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DIV0      = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PD_NONE,
      PD_MUL,
      PD_DIV
   } pend_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       last;
   } item_type;

endpackage

@@ src/idee_front.sv @@
// ----------------------------------------------------------------------------
// idee_front: input handshake and character classifier
// Sorts each character into digit, operator or other and pushes it to the queue.
// ----------------------------------------------------------------------------
module idee_front import idee_pkg::*; (
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_last,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic [7:0] digit_off;

   always_comb begin
      digit_off    = req_char_code - CH_ZERO;
      q_item.digit = digit_off[3:0];
      q_item.last  = req_last;
      priority if (req_char_code >= CH_ZERO && req_char_code <= CH_NINE) begin
         q_item.kind = K_DIGIT;
      end else if (req_char_code == CH_PLUS) begin
         q_item.kind = K_ADD;
      end else if (req_char_code == CH_MINUS) begin
         q_item.kind = K_SUB;
      end else if (req_char_code == CH_STAR) begin
         q_item.kind = K_MUL;
      end else if (req_char_code == CH_SLASH) begin
         q_item.kind = K_DIV;
      end else begin
         q_item.kind = K_OTHER;
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

@@ src/idee_queue.sv @@
// ----------------------------------------------------------------------------
// idee_queue: short item queue between front and back
// Two-entry FIFO of classified characters.
// ----------------------------------------------------------------------------
module idee_queue import idee_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_item  = slot_ff[rd_ff];

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("queue count did not advance on push");
`endif

endmodule

@@ src/idee_back.sv @@
// ----------------------------------------------------------------------------
// idee_back: evaluation engine
// Keeps sum and term, multiplies by a digit, divides by a digit in a
// bit-serial divider, and registers the final value and status.
// ----------------------------------------------------------------------------
module idee_back import idee_pkg::*; #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  item_type           pop_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [OUT_W-1:0]   rsp_value,
   output logic [1:0]         rsp_status
);

   localparam int unsigned VW     = VALUE_WIDTH;
   localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned PROD_W = VALUE_WIDTH + 5;

   back_state_type     state_ff, state_in;
   logic [VW-1:0]      sum_ff, sum_in;
   logic [VW-1:0]      term_ff, term_in;
   logic               sign_ff, sign_in;
   pend_type           pend_ff, pend_in;
   logic               expect_ff, expect_in;
   logic               start_ff, start_in;
   status_type         err_ff, err_in;
   logic               fin_ff, fin_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VW-1:0]      quo_ff, quo_in;
   logic [3:0]         rem_ff, rem_in;
   logic [3:0]         dvs_ff, dvs_in;
   logic               dneg_ff, dneg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_value_ff, rsp_value_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic signed [PROD_W-1:0] prod;
   logic                     prod_ovf;
   logic [VW-1:0]            commit_val;
   logic                     commit_ovf;
   logic [VW-1:0]            term_mag;
   logic [4:0]               part;
   logic [4:0]               part_diff;
   logic                     part_ge;
   logic [3:0]               rem_next;
   logic [VW-1:0]            quo_step;
   logic [VW-1:0]            quo_done;
   logic                     start_div;
   logic                     is_addsub;
   logic                     flag_en;
   status_type               flag_code;
   status_type               fin_err;
   logic [VW-1:0]            fin_val;

   always_comb begin
      prod     = PROD_W'($signed(term_ff)) * PROD_W'($signed({1'b0, pop_item.digit}));
      prod_ovf = !((&prod[PROD_W-1:VW-1]) || !(|prod[PROD_W-1:VW-1]));
      if (sign_ff) begin
         commit_val = sum_ff - term_ff;
         commit_ovf = (sum_ff[VW-1] != term_ff[VW-1]) && (commit_val[VW-1] != sum_ff[VW-1]);
      end else begin
         commit_val = sum_ff + term_ff;
         commit_ovf = (sum_ff[VW-1] == term_ff[VW-1]) && (commit_val[VW-1] != sum_ff[VW-1]);
      end
      term_mag  = term_ff[VW-1] ? -term_ff : term_ff;
      part      = {rem_ff, quo_ff[VW-1]};
      part_diff = part - {1'b0, dvs_ff};
      part_ge   = (part >= {1'b0, dvs_ff});
      rem_next  = part_ge ? part_diff[3:0] : part[3:0];
      quo_step  = {quo_ff[VW-2:0], part_ge};
      quo_done  = dneg_ff ? -quo_step : quo_step;
      is_addsub = (pop_item.kind == K_ADD) || (pop_item.kind == K_SUB);
      start_div = expect_ff && (pop_item.kind == K_DIGIT) && (pend_ff == PD_DIV)
                  && (pop_item.digit != 4'd0);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               if (start_div) begin
                  state_in = BK_DIV;
               end else if (pop_item.last) begin
                  state_in = BK_FIN;
               end
            end
         end
         BK_DIV: begin
            if (cnt_ff == CNT_W'(1)) begin
               state_in = fin_ff ? BK_FIN : BK_IDLE;
            end
         end
         BK_FIN: begin
            if (!rsp_valid_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      sum_in        = sum_ff;
      term_in       = term_ff;
      sign_in       = sign_ff;
      pend_in       = pend_ff;
      expect_in     = expect_ff;
      start_in      = start_ff;
      err_in        = err_ff;
      fin_in        = fin_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      dneg_in       = dneg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      flag_en       = 1'b0;
      flag_code     = ST_OK;
      fin_err       = err_ff;
      fin_val       = '0;
      pop           = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               pop    = 1'b1;
               fin_in = pop_item.last;
               if (expect_ff) begin
                  if (pop_item.kind == K_DIGIT) begin
                     unique case (pend_ff)
                        PD_MUL: begin
                           term_in   = prod[VW-1:0];
                           flag_en   = prod_ovf;
                           flag_code = ST_OVERFLOW;
                        end
                        PD_DIV: begin
                           if (pop_item.digit == 4'd0) begin
                              flag_en   = 1'b1;
                              flag_code = ST_DIV0;
                              term_in   = '0;
                           end else begin
                              dvs_in  = pop_item.digit;
                              dneg_in = term_ff[VW-1];
                              quo_in  = term_mag;
                              rem_in  = '0;
                              cnt_in  = CNT_W'(VW);
                           end
                        end
                        default: term_in = VW'(pop_item.digit);
                     endcase
                     pend_in   = PD_NONE;
                     expect_in = 1'b0;
                  end else if (is_addsub && start_ff) begin
                     sum_in  = '0;
                     term_in = '0;
                     sign_in = (pop_item.kind == K_SUB);
                     pend_in = PD_NONE;
                  end else begin
                     flag_en   = 1'b1;
                     flag_code = ST_MALFORMED;
                  end
               end else begin
                  if (pop_item.kind == K_MUL || pop_item.kind == K_DIV) begin
                     pend_in   = (pop_item.kind == K_MUL) ? PD_MUL : PD_DIV;
                     expect_in = 1'b1;
                  end else if (is_addsub) begin
                     sum_in    = commit_val;
                     flag_en   = commit_ovf;
                     flag_code = ST_OVERFLOW;
                     term_in   = '0;
                     sign_in   = (pop_item.kind == K_SUB);
                     pend_in   = PD_NONE;
                     expect_in = 1'b1;
                  end else begin
                     flag_en   = 1'b1;
                     flag_code = ST_MALFORMED;
                  end
               end
               start_in = 1'b0;
            end
         end
         BK_DIV: begin
            quo_in = quo_step;
            rem_in = rem_next;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               term_in = quo_done;
            end
         end
         BK_FIN: begin
            if (!rsp_valid_ff) begin
               if (err_ff == ST_OK) begin
                  if (expect_ff) begin
                     fin_err = ST_MALFORMED;
                  end else if (commit_ovf) begin
                     fin_err = ST_OVERFLOW;
                  end
               end
               fin_val = expect_ff ? '0 : commit_val;
               if (fin_err == ST_DIV0 || fin_err == ST_MALFORMED) begin
                  fin_val = '0;
               end
               rsp_value_in  = OUT_W'($signed(fin_val));
               rsp_status_in = fin_err;
               rsp_valid_in  = 1'b1;
               sum_in        = '0;
               term_in       = '0;
               sign_in       = 1'b0;
               pend_in       = PD_NONE;
               expect_in     = 1'b1;
               start_in      = 1'b1;
               err_in        = ST_OK;
               fin_in        = 1'b0;
            end
         end
         default: ;
      endcase
      if (flag_en && err_ff == ST_OK) begin
         err_in = flag_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         term_ff      <= '0;
         sign_ff      <= 1'b0;
         pend_ff      <= PD_NONE;
         expect_ff    <= 1'b1;
         start_ff     <= 1'b1;
         err_ff       <= ST_OK;
         fin_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         sign_ff      <= sign_in;
         pend_ff      <= pend_in;
         expect_ff    <= expect_in;
         start_ff     <= start_in;
         err_ff       <= err_in;
         fin_ff       <= fin_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dvs_ff        <= dvs_in;
      dneg_ff       <= dneg_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FIN && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("final result not registered");
   a_div_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV) |-> (dvs_ff != 4'd0 && cnt_ff != '0))
      else $error("divider running with zero divisor or count");
   a_fresh_after_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FIN && !rsp_valid_ff) |=> (start_ff && expect_ff && err_ff == ST_OK))
      else $error("state not cleared after result");
`endif

endmodule

@@ src/infix_digit_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// infix_digit_expression_evaluator: single-digit infix expression evaluator
// Evaluates + - * / over digits with the usual precedence, one character
// per beat, and returns value and status on the final character.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one ASCII character per beat, req_last on the final one.
//   rsp_ channel: one beat per expression, rsp_value (32-bit signed) and
//   rsp_status (ok, division by zero, malformed, overflow).
//   A two-entry queue sits between the classifier and the evaluation engine,
//   so req_ready stays high while the engine is busy until the queue fills.
//   The engine pops a character whenever it is idle; a digit after '/' is
//   popped and then divided in the bit-serial divider, and the engine takes
//   no new character until the divider is done or a final one is finished.
//   A final character goes through the queue and the engine, and through
//   the divider when it divides; the finish state registers the result.
//   A stalled result holds in the output register; the engine waits for it
//   to drain only when the next result is due, and keeps accepting beats
//   until the queue fills.
//   Reset clears sum, term and control state at once; no warm-up is needed.
// ----------------------------------------------------------------------------
module infix_digit_expression_evaluator import idee_pkg::*; #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);

   logic     q_full;
   logic     q_push;
   item_type q_item;
   logic     q_pop_valid;
   item_type q_pop_item;
   logic     q_pop;

   idee_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (q_item)
   );

   idee_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop_valid (q_pop_valid),
      .pop_item  (q_pop_item),
      .pop       (q_pop)
   );

   idee_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_valid),
      .pop_item   (q_pop_item),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule
